// ===== rtl/mta_pkg.sv =====
`default_nettype none

package mta_pkg;

    // Field widths fixed by the register map and the result format
    localparam int THR_W  = 16;
    localparam int MOV_W  = 4;
    localparam int LOSS_W = 4;
    localparam int BEEP_W = 6;
    localparam int CNT_W  = 7;
    localparam int TC_W   = 3;
    localparam int SEQ_W  = 32;
    localparam int ACC_W  = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_MOVING    = 2'd1;
    localparam logic [1:0] CFG_LOSS      = 2'd2;
    localparam logic [1:0] CFG_BEEP      = 2'd3;

    // Register reset values
    localparam logic [THR_W-1:0]  THR_RST  = 16'd256;
    localparam logic [MOV_W-1:0]  MLIM_RST = 4'd4;
    localparam logic [LOSS_W-1:0] LLIM_RST = 4'd8;
    localparam logic [BEEP_W-1:0] BLIM_RST = 6'd16;

    // Tamper countdown load value
    localparam logic [TC_W-1:0] TAMPER_LOAD = 3'd5;

    // Send kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_BEACON = 2'd1;
    localparam logic [1:0] KIND_PROBE  = 2'd2;

    // Sound events
    localparam logic [2:0] SND_NONE   = 3'd0;
    localparam logic [2:0] SND_DISARM = 3'd1;
    localparam logic [2:0] SND_ARM    = 3'd2;
    localparam logic [2:0] SND_BEEP   = 3'd3;
    localparam logic [2:0] SND_PRIMED = 3'd4;

    // Sleep classes
    localparam logic [1:0] SLP_SHORT = 2'd0;
    localparam logic [1:0] SLP_LONG  = 2'd1;
    localparam logic [1:0] SLP_ALARM = 2'd2;

    typedef struct packed {
        logic signed [ACC_W-1:0] accel_x;
        logic signed [ACC_W-1:0] accel_y;
        logic signed [ACC_W-1:0] accel_z;
        logic                    send_acked;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       send_kind;
        logic [SEQ_W-1:0] sent_sequence;
        logic [MOV_W-1:0] sent_moving;
        logic [2:0]       sound_event;
        logic [1:0]       sleep_class;
        logic             alarm_armed;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       wr_index;
        logic [THR_W-1:0] wr_data;
    } t_cfg_wr;

    typedef struct packed {
        logic [THR_W-1:0]  thr;
        logic [MOV_W-1:0]  mlim;
        logic [LOSS_W-1:0] llim;
        logic [BEEP_W-1:0] blim;
    } t_cfg;

    // Per-item flags carried down the pipeline
    typedef struct packed {
        logic acked;
        logic primed_old;
        logic fill_done;
    } t_flags;

endpackage

`default_nettype wire

// ===== rtl/mta_chan_if.sv =====
`default_nettype none

interface mta_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mta_cell.sv =====
`default_nettype none

module mta_cell #(
    parameter int SW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic signed [SW-1:0] i_smp [3],
    output logic signed [SW-1:0] o_smp [3]
);
    logic signed [SW-1:0] r_smp [3];
    logic signed [SW-1:0] n_smp [3];

    // Take the neighbor's sample set on a shift
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_smp[a] = i_shift ? i_smp[a] : r_smp[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_smp[a] <= '0;
            end
        end else begin
            r_smp <= n_smp;
        end
    end

    assign o_smp = r_smp;

endmodule

`default_nettype wire

// ===== rtl/mta_window.sv =====
`default_nettype none

module mta_window #(
    parameter int DEPTH = 10,
    parameter int SW    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [SW-1:0] i_smp [3],
    input  logic                 i_acked,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [SW-1:0] o_smp [3],
    output mta_pkg::t_flags      o_flags,
    output logic [2:0]           o_neg,
    output logic [SW+$clog2(DEPTH)-1:0] o_abs [3]
);
    import mta_pkg::*;

    localparam int LG     = $clog2(DEPTH);
    localparam int SUM_W  = SW + LG;
    localparam int FILL_W = (LG < 1) ? 1 : LG;

    logic signed [SW-1:0]    w [DEPTH+1][3];
    logic signed [SUM_W-1:0] r_sum [3];
    logic signed [SUM_W-1:0] n_sum [3];
    logic [SUM_W-1:0]        n_abs [3];
    logic [2:0]              n_neg;
    logic [FILL_W-1:0]       r_fill;
    logic                    r_primed;
    logic                    r_v;
    logic signed [SW-1:0]    r_smp [3];
    t_flags                  r_flags;
    logic [2:0]              r_neg;
    logic [SUM_W-1:0]        r_abs [3];
    logic                    accept;
    logic                    fill_last;

    assign o_ready   = !r_v || i_ready;
    assign accept    = i_valid && o_ready;
    assign fill_last = (r_fill == FILL_W'(DEPTH - 1));

    // Row of window cells; the newest sample enters cell 0, the oldest leaves the end
    assign w[0] = i_smp;
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        mta_cell #(.SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept),
            .i_smp   (w[k]),
            .o_smp   (w[k+1])
        );
    end

    // Running sums and their magnitude for the reciprocal divide
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_sum[a] = r_sum[a] + SUM_W'(i_smp[a]) - SUM_W'(w[DEPTH][a]);
            n_neg[a] = n_sum[a][SUM_W-1];
            n_abs[a] = n_neg[a] ? SUM_W'(-n_sum[a]) : SUM_W'(n_sum[a]);
        end
    end

    // Sums, fill count and primed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
            end
            r_fill   <= '0;
            r_primed <= 1'b0;
        end else if (accept) begin
            r_sum <= n_sum;
            if (!r_primed) begin
                if (fill_last) begin
                    r_fill   <= '0;
                    r_primed <= 1'b1;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // Stage register toward the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (i_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp              <= i_smp;
            r_neg              <= n_neg;
            r_abs              <= n_abs;
            r_flags.acked      <= i_acked;
            r_flags.primed_old <= r_primed;
            r_flags.fill_done  <= !r_primed && fill_last;
        end
    end

    assign o_valid = r_v;
    assign o_smp   = r_smp;
    assign o_flags = r_flags;
    assign o_neg   = r_neg;
    assign o_abs   = r_abs;

endmodule

`default_nettype wire

// ===== rtl/mta_detect.sv =====
`default_nettype none

module mta_detect #(
    parameter int DEPTH = 10,
    parameter int SW    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [SW-1:0] i_smp [3],
    input  mta_pkg::t_flags      i_flags,
    input  logic [2:0]           i_neg,
    input  logic [SW+$clog2(DEPTH)-1:0] i_abs [3],
    input  logic [mta_pkg::THR_W-1:0]   i_thr,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mta_pkg::t_flags      o_flags,
    output logic                 o_dev
);
    import mta_pkg::*;

    localparam int LG     = $clog2(DEPTH);
    localparam int SUM_W  = SW + LG;
    localparam int DIF_W  = SUM_W + 1;
    localparam int CMP_W  = (DIF_W > THR_W) ? DIF_W : THR_W;
    localparam int K      = SUM_W + LG;
    localparam int M_W    = SUM_W + 2;
    localparam int PROD_W = SUM_W + M_W;
    // Rounded-up reciprocal; exact truncated quotient for every sum magnitude
    localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [M_W-1:0] RECIP = RECIP64[M_W-1:0];

    logic                    r2_v;
    logic [PROD_W-1:0]       r2_prod [3];
    logic [2:0]              r2_neg;
    logic signed [SW-1:0]    r2_smp [3];
    t_flags                  r2_flags;
    logic                    r3_v;
    t_flags                  r3_flags;
    logic                    r3_dev;
    logic                    s2_take;
    logic                    s3_ready;
    logic                    s3_take;
    logic [SUM_W-1:0]        q [3];
    logic signed [SUM_W-1:0] mean [3];
    logic signed [DIF_W-1:0] dif [3];
    logic [DIF_W-1:0]        adif [3];
    logic                    dev;

    assign s3_ready = !r3_v || i_ready;
    assign o_ready  = !r2_v || s3_ready;
    assign s2_take  = i_valid && o_ready;
    assign s3_take  = r2_v && s3_ready;

    // Reciprocal multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (s2_take) begin
            r2_v <= 1'b1;
        end else if (s3_ready) begin
            r2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take) begin
            for (int a = 0; a < 3; a++) begin
                r2_prod[a] <= PROD_W'(i_abs[a]) * PROD_W'(RECIP);
            end
            r2_neg   <= i_neg;
            r2_smp   <= i_smp;
            r2_flags <= i_flags;
        end
    end

    // Signed mean, deviation magnitude and threshold compare on each axis
    always_comb begin
        dev = 1'b0;
        for (int a = 0; a < 3; a++) begin
            q[a]    = SUM_W'(r2_prod[a] >> K);
            mean[a] = r2_neg[a] ? -$signed(q[a]) : $signed(q[a]);
            dif[a]  = DIF_W'(mean[a]) - DIF_W'(r2_smp[a]);
            adif[a] = dif[a][DIF_W-1] ? DIF_W'(-dif[a]) : DIF_W'(dif[a]);
            if (CMP_W'(adif[a]) >= CMP_W'(i_thr)) begin
                dev = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (s3_take) begin
            r3_v <= 1'b1;
        end else if (i_ready) begin
            r3_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_take) begin
            r3_flags <= r2_flags;
            r3_dev   <= dev;
        end
    end

    assign o_valid = r3_v;
    assign o_flags = r3_flags;
    assign o_dev   = r3_dev;

endmodule

`default_nettype wire

// ===== rtl/mta_ctrl.sv =====
`default_nettype none

module mta_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mta_pkg::t_flags     i_flags,
    input  logic                i_dev,
    input  mta_pkg::t_cfg       i_cfg,
    output logic                o_valid,
    input  logic                i_ready,
    output mta_pkg::t_out_item  o_item
);
    import mta_pkg::*;

    logic [SEQ_W-1:0]  r_seq, n_seq, seq_inc;
    logic [TC_W-1:0]   r_tc, n_tc;
    logic [MOV_W-1:0]  r_mov, n_mov;
    logic [LOSS_W-1:0] r_loss, n_loss;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_off, n_off;
    logic              r_v;
    t_out_item         r_item, n_item;
    logic              probe;
    logic              run_tail;
    logic              take;

    assign o_ready = !r_v || i_ready;
    assign take    = i_valid && o_ready;
    assign seq_inc = r_seq + 1'b1;
    assign probe   = !r_off && (r_cnt != '0) && seq_inc[0];

    // One wake cycle of the send, arm/disarm, tamper and sleep decisions
    always_comb begin
        n_seq    = r_seq;
        n_tc     = r_tc;
        n_mov    = r_mov;
        n_loss   = r_loss;
        n_cnt    = r_cnt;
        n_off    = r_off;
        n_item   = '0;
        run_tail = 1'b1;

        if (i_flags.primed_old) begin
            n_seq                = seq_inc;
            n_item.send_kind     = probe ? KIND_PROBE : KIND_BEACON;
            n_item.sent_sequence = seq_inc;
            n_item.sent_moving   = probe ? '0 : r_mov;
            if (i_flags.acked) begin
                if (probe) begin
                    if (!r_off) begin
                        n_item.sound_event = SND_DISARM;
                        n_off              = 1'b1;
                    end
                end else if (r_off || r_cnt != '0) begin
                    n_item.sound_event = SND_ARM;
                    n_cnt              = '0;
                    n_off              = 1'b0;
                end
                n_tc   = '0;
                n_mov  = '0;
                n_loss = '0;
            end else if (!r_off && r_mov != '0) begin
                if (r_loss < i_cfg.llim) begin
                    n_loss = r_loss + 1'b1;
                end else begin
                    n_tc = TAMPER_LOAD;
                end
            end
            if (i_dev) begin
                n_tc = TAMPER_LOAD;
            end
        end else if (i_flags.fill_done) begin
            n_item.sound_event = SND_PRIMED;
        end else begin
            n_item.sleep_class = SLP_SHORT;
            run_tail           = 1'b0;
        end

        // Moving count, beep escalation and sleep class
        if (run_tail) begin
            if (n_tc != '0 && !n_off) begin
                n_tc = n_tc - 1'b1;
                if (n_mov < i_cfg.mlim) begin
                    n_item.sleep_class = SLP_SHORT;
                    n_mov              = n_mov + 1'b1;
                end else begin
                    n_item.sleep_class = SLP_ALARM;
                    n_item.sound_event = SND_BEEP;
                    if (n_cnt <= CNT_W'(i_cfg.blim)) begin
                        n_cnt = n_cnt + 1'b1;
                    end else begin
                        n_off = 1'b1;
                    end
                end
            end else begin
                n_item.sleep_class = (n_loss != '0 && !n_off) ? SLP_SHORT : SLP_LONG;
                n_mov              = '0;
            end
        end

        n_item.alarm_armed = !n_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= '0;
            r_tc   <= '0;
            r_mov  <= '0;
            r_loss <= '0;
            r_cnt  <= CNT_W'(1);
            r_off  <= 1'b1;
            r_v    <= 1'b0;
        end else begin
            if (take) begin
                r_seq  <= n_seq;
                r_tc   <= n_tc;
                r_mov  <= n_mov;
                r_loss <= n_loss;
                r_cnt  <= n_cnt;
                r_off  <= n_off;
                r_v    <= 1'b1;
            end else if (i_ready) begin
                r_v <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_v;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/motion_tamper_alarm_unit.sv =====
`default_nettype none

// Motion tamper alarm. Each transaction on i_item is one wake cycle: a
// three-axis accelerometer sample plus the acknowledge of that cycle's send;
// each produces exactly one transaction on o_result with the send kind,
// sequence, sound event, sleep class and armed state. The block takes one
// transaction per clock while o_result is ready, and its result is registered
// in the sample window (a shifting row of WINDOW_DEPTH cells with
// running per-axis sums), in the reciprocal multiply that forms the
// truncated mean, in the deviation compare and in the control
// register that holds the alarm state and the result. i_item.ready drops
// only while the result register and every stage behind it are full.
// Registers on i_cfg (deviation threshold, moving limit, loss limit, beep
// limit) are always ready for a write and must only be written while no
// transaction is in flight.
module motion_tamper_alarm_unit #(
    parameter int WINDOW_DEPTH = 10,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mta_chan_if.sink    i_item,
    mta_chan_if.source  o_result,
    mta_chan_if.sink    i_cfg
);
    import mta_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH);

    t_cfg                         r_cfg;
    logic signed [SAMPLE_BITS-1:0] smp [3];
    logic signed [SAMPLE_BITS-1:0] w_smp [3];
    t_flags                       w_flags;
    logic [2:0]                   w_neg;
    logic [SUM_W-1:0]             w_abs [3];
    logic                         w_valid;
    logic                         d_ready;
    t_flags                       d_flags;
    logic                         d_dev;
    logic                         d_valid;
    logic                         c_ready;
    logic                         cfg_wr;

    // Sample extraction: low SAMPLE_BITS bits taken as they are, wider widths zero filled
    if (SAMPLE_BITS <= ACC_W) begin : g_narrow
        assign smp[0] = i_item.data.accel_x[SAMPLE_BITS-1:0];
        assign smp[1] = i_item.data.accel_y[SAMPLE_BITS-1:0];
        assign smp[2] = i_item.data.accel_z[SAMPLE_BITS-1:0];
    end else begin : g_wide
        assign smp[0] = {{(SAMPLE_BITS-ACC_W){1'b0}}, i_item.data.accel_x};
        assign smp[1] = {{(SAMPLE_BITS-ACC_W){1'b0}}, i_item.data.accel_y};
        assign smp[2] = {{(SAMPLE_BITS-ACC_W){1'b0}}, i_item.data.accel_z};
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr  <= THR_RST;
            r_cfg.mlim <= MLIM_RST;
            r_cfg.llim <= LLIM_RST;
            r_cfg.blim <= BLIM_RST;
        end else if (cfg_wr) begin
            case (i_cfg.data.wr_index)
                CFG_THRESHOLD: r_cfg.thr  <= i_cfg.data.wr_data;
                CFG_MOVING:    r_cfg.mlim <= i_cfg.data.wr_data[MOV_W-1:0];
                CFG_LOSS:      r_cfg.llim <= i_cfg.data.wr_data[LOSS_W-1:0];
                CFG_BEEP:      r_cfg.blim <= i_cfg.data.wr_data[BEEP_W-1:0];
                default:       r_cfg      <= r_cfg;
            endcase
        end
    end

    mta_window #(.DEPTH(WINDOW_DEPTH), .SW(SAMPLE_BITS)) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_smp   (smp),
        .i_acked (i_item.data.send_acked),
        .o_valid (w_valid),
        .i_ready (d_ready),
        .o_smp   (w_smp),
        .o_flags (w_flags),
        .o_neg   (w_neg),
        .o_abs   (w_abs)
    );

    mta_detect #(.DEPTH(WINDOW_DEPTH), .SW(SAMPLE_BITS)) u_detect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .o_ready (d_ready),
        .i_smp   (w_smp),
        .i_flags (w_flags),
        .i_neg   (w_neg),
        .i_abs   (w_abs),
        .i_thr   (r_cfg.thr),
        .o_valid (d_valid),
        .i_ready (c_ready),
        .o_flags (d_flags),
        .o_dev   (d_dev)
    );

    mta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .o_ready (c_ready),
        .i_flags (d_flags),
        .i_dev   (d_dev),
        .i_cfg   (r_cfg),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_item  (o_result.data)
    );

    // A threshold write lands in the register in the next cycle
    a_thr_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && i_cfg.data.wr_index == CFG_THRESHOLD
        |=> r_cfg.thr == $past(i_cfg.data.wr_data))
        else $error("threshold register write lost");

    // A beep always comes with the alarm sleep class
    a_beep_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.data.sound_event == SND_BEEP
        |-> o_result.data.sleep_class == SLP_ALARM)
        else $error("alarm beep without alarm sleep");

    // No result is presented right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
